[rtl/block_free_list_allocator_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the free list allocator
// Shared property forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef BLOCK_FREE_LIST_ALLOCATOR_ASSERT_SVH
`define BLOCK_FREE_LIST_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define BFLA_ASSERT_NOW(lbl, ck, rstn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("bfla: same-cycle check failed");

// next-cycle implication
`define BFLA_ASSERT_NXT(lbl, ck, rstn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("bfla: next-cycle check failed");

`endif

[rtl/bfla_pkg.sv]
// ----------------------------------------------------------------------------
// bfla_pkg
// Widths, codes and shared types of the free list allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bfla_pkg;

    localparam int ID_W        = 10;
    localparam int HEAD_W      = 11;
    localparam int STATUS_W    = 2;
    localparam int ID_LIMIT    = 1 << ID_W;
    localparam int NUM_BLOCKS_DEF = 1024;

    // operation codes
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_FREE = 2'd2;

    // controller -> datapath commands
    typedef struct packed {
        logic capture;   // word accepted: latch it, fetch link of head
        logic commit;    // apply operation, load result register
    } ctl_t;

endpackage

`default_nettype wire

[rtl/bfla_ifs.sv]
// ----------------------------------------------------------------------------
// Allocator channels
// Request and response valid/ready channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface bfla_req_if;
    logic                      valid;
    logic                      ready;
    logic                      cmd;
    logic [bfla_pkg::ID_W-1:0] block_id;

    modport source (output valid, cmd, block_id, input ready);
    modport sink   (input valid, cmd, block_id, output ready);
endinterface

interface bfla_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [bfla_pkg::ID_W-1:0]     alloc_id;
    logic [bfla_pkg::STATUS_W-1:0] status;
    logic [bfla_pkg::ID_W-1:0]     live_count;

    modport source (output valid, alloc_id, status, live_count, input ready);
    modport sink   (input valid, alloc_id, status, live_count, output ready);
endinterface

`default_nettype wire

[rtl/bfla_ram.sv]
// ----------------------------------------------------------------------------
// bfla_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bfla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[rtl/bfla_ctrl.sv]
// ----------------------------------------------------------------------------
// bfla_ctrl
// Sequencer: take a word, execute it, hand it to the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bfla_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  wire logic           out_ready,
    output bfla_pkg::ctl_t      ctl
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic state_reg, state_next;
    logic out_valid_reg, out_valid_next;

    always_comb
    begin
        in_ready    = (state_reg == S_IDLE);
        ctl.capture = in_valid && in_ready;
        // result slot free now or emptied this cycle
        ctl.commit  = (state_reg == S_EXEC) && (!out_valid_reg || out_ready);

        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (ctl.capture)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (ctl.commit)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_valid_next = out_valid_reg;
        if (ctl.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

[rtl/bfla_dpath.sv]
// ----------------------------------------------------------------------------
// bfla_dpath
// Allocator state, link memory, operation decode and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bfla_dpath #(
    parameter int NUM_BLOCKS = bfla_pkg::NUM_BLOCKS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire bfla_pkg::ctl_t                ctl,
    input  wire logic                          in_cmd,
    input  wire logic [bfla_pkg::ID_W-1:0]     in_block_id,
    output logic      [bfla_pkg::ID_W-1:0]     alloc_id,
    output logic      [bfla_pkg::STATUS_W-1:0] status,
    output logic      [bfla_pkg::ID_W-1:0]     live_count
);

    localparam int ID_W     = bfla_pkg::ID_W;
    localparam int HEAD_W   = bfla_pkg::HEAD_W;
    // link words needed: one per block the id field can name
    localparam int DEPTH    = (NUM_BLOCKS > bfla_pkg::ID_LIMIT) ? bfla_pkg::ID_LIMIT
                                                                : NUM_BLOCKS;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam logic [ID_W-1:0] LAST   = ID_W'(DEPTH - 1);
    localparam logic [ID_W-1:0] ID_MAX = '1;

    logic                 cmd_reg;
    logic [ID_W-1:0]      id_reg;
    logic [ID_W-1:0]      live_reg, live_next;
    logic [ID_W-1:0]      hw_reg, hw_next;
    logic [HEAD_W-1:0]    head_reg, head_next;
    logic [ID_W-1:0]      alloc_id_reg, alloc_id_next;
    logic [bfla_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [ID_W-1:0]      live_out_reg;
    logic [HEAD_W-1:0]    link_rdata;
    logic                 link_we;
    logic                 list_ok;
    logic                 free_bad;
    logic [ID_W-1:0]      live_inc, live_dec;

    // link word of the current head is fetched as the word is taken; the
    // head cannot move before this word commits
    bfla_ram #(
        .WIDTH (HEAD_W),
        .DEPTH (DEPTH)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (id_reg[ADDR_W-1:0]),
        .wdata (head_reg),
        .re    (ctl.capture),
        .raddr (head_reg[ADDR_W-1:0]),
        .rdata (link_rdata)
    );

    always_comb
    begin
        list_ok  = (live_reg < hw_reg) && (head_reg != '0)
                   && (head_reg <= {1'b0, hw_reg});
        free_bad = (id_reg == '0) || (id_reg > hw_reg);
        live_inc = (live_reg == ID_MAX) ? live_reg : live_reg + 1'b1;
        live_dec = (live_reg == '0) ? live_reg : live_reg - 1'b1;

        live_next     = live_reg;
        hw_next       = hw_reg;
        head_next     = head_reg;
        alloc_id_next = '0;
        status_next   = bfla_pkg::ST_OK;
        link_we       = 1'b0;

        if (cmd_reg == bfla_pkg::CMD_ALLOC)
        begin
            if (list_ok)
            begin
                alloc_id_next = head_reg[ID_W-1:0];
                head_next     = link_rdata;
                live_next     = live_inc;
            end
            else if (hw_reg < LAST)
            begin
                hw_next       = hw_reg + 1'b1;
                alloc_id_next = hw_reg + 1'b1;
                head_next     = {1'b0, hw_reg} + HEAD_W'(2);
                live_next     = live_inc;
            end
            else
            begin
                status_next = bfla_pkg::ST_FULL;
            end
        end
        else
        begin
            if (free_bad)
            begin
                status_next = bfla_pkg::ST_BAD_FREE;
            end
            else
            begin
                link_we   = ctl.commit;
                head_next = {1'b0, id_reg};
                live_next = live_dec;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg <= '0;
            hw_reg   <= '0;
            head_reg <= HEAD_W'(1);
        end
        else if (ctl.commit)
        begin
            live_reg <= live_next;
            hw_reg   <= hw_next;
            head_reg <= head_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            cmd_reg <= in_cmd;
            id_reg  <= in_block_id;
        end
        if (ctl.commit)
        begin
            alloc_id_reg <= alloc_id_next;
            status_reg   <= status_next;
            live_out_reg <= live_next;
        end
    end

    assign alloc_id   = alloc_id_reg;
    assign status     = status_reg;
    assign live_count = live_out_reg;

endmodule

`default_nettype wire

[rtl/block_free_list_allocator.sv]
// ----------------------------------------------------------------------------
// block_free_list_allocator
// Free list block allocator with high-water mark.
//
// req  (sink):   cmd 0 = allocate, 1 = free block_id. One word in flight.
// rsp  (source): alloc_id, status (ok / full / bad free), live_count.
// Each request word gives exactly one response word.
// An accepted request moves to execute; its result is loaded into the output
// register once that register is free. A new request is taken only after the
// last one has executed. The link RAM read for the free list head is issued
// on accept and used in execute.
// A finished response sits in an output register, so the next request is
// taken while rsp is stalled; that request then waits in execute until the
// output register frees up, and req.ready stays low meanwhile.
// Reset: live count and high-water mark clear, head goes to block 1, no
// response pending. Link RAM is not cleared; no pass is needed since a link
// word is only used after it was written, barring double frees.
// ----------------------------------------------------------------------------
`default_nettype none

module block_free_list_allocator #(
    parameter int NUM_BLOCKS = bfla_pkg::NUM_BLOCKS_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    bfla_req_if.sink   req,
    bfla_rsp_if.source rsp
);

    bfla_pkg::ctl_t ctl;

    // sequencer
    bfla_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .ctl       (ctl)
    );

    // state, link RAM and result register
    bfla_dpath #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .in_cmd      (req.cmd),
        .in_block_id (req.block_id),
        .alloc_id    (rsp.alloc_id),
        .status      (rsp.status),
        .live_count  (rsp.live_count)
    );

endmodule

`default_nettype wire

[rtl/bfla_checker.sv]
// ----------------------------------------------------------------------------
// bfla_checker
// Port-level checks on the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "block_free_list_allocator_assert.svh"

module bfla_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          req_valid,
    input wire logic                          req_ready,
    input wire logic                          rsp_valid,
    input wire logic                          rsp_ready,
    input wire logic [bfla_pkg::ID_W-1:0]     rsp_alloc_id,
    input wire logic [bfla_pkg::STATUS_W-1:0] rsp_status,
    input wire logic [bfla_pkg::ID_W-1:0]     rsp_live_count
);

    // one word in flight: no accept right after an accept
    `BFLA_ASSERT_NXT(a_one_in_flight, clk, rst_n, req_valid && req_ready, !req_ready)

    // refused operations grant nothing
    `BFLA_ASSERT_NOW(a_refused_no_grant, clk, rst_n, rsp_valid && (rsp_status != bfla_pkg::ST_OK), rsp_alloc_id == '0)

    // a granted block is counted live
    `BFLA_ASSERT_NOW(a_grant_counted, clk, rst_n, rsp_valid && (rsp_alloc_id != '0), rsp_live_count != '0)

    // stalled response holds
    `BFLA_ASSERT_NXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_alloc_id) && $stable(rsp_status) && $stable(rsp_live_count))

endmodule

bind block_free_list_allocator bfla_checker u_bfla_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_alloc_id   (rsp.alloc_id),
    .rsp_status     (rsp.status),
    .rsp_live_count (rsp.live_count)
);

`default_nettype wire
